### sv/ecapd_pkg.sv
// ----------------------------------------------------------------------------
// ecapd_pkg
// Shared types and constants for the affine point add/double unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecapd_pkg;

  // default field width in bits
  localparam int unsigned FIELD_WIDTH_DEF = 64;

  // configuration register index width and indexes
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS = 1'b0,
    REG_CURVE_A = 1'b1
  } cfg_reg_e;

  // operations of the shared arithmetic unit
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_RED = 3'd2,
    ALU_MUL = 3'd3,
    ALU_DIV = 3'd4
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RPX,
    ST_RPY,
    ST_RQX,
    ST_RQY,
    ST_RCA,
    ST_CHK,
    ST_NUM_SUB,
    ST_DEN_SUB,
    ST_SQX,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_D2,
    ST_INIT,
    ST_ITEST,
    ST_IDIV,
    ST_IRED,
    ST_IMUL,
    ST_ISUB,
    ST_LAM,
    ST_X1,
    ST_X2,
    ST_X3,
    ST_Y1,
    ST_Y2,
    ST_Y3,
    ST_DONE
  } st_e;

endpackage

`default_nettype wire

### sv/ecapd_alu.sv
// ----------------------------------------------------------------------------
// ecapd_alu
// Shared modular arithmetic unit: add, subtract, single reduction step,
// bit-serial multiply and bit-serial restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module ecapd_alu #(
  parameter int unsigned W = ecapd_pkg::FIELD_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ecapd_pkg::alu_req_t req_i,
  input  wire logic [W-1:0]       a_i,
  input  wire logic [W-1:0]       b_i,
  input  wire logic [W-1:0]       m_i,
  output logic [W-1:0]            res_o,
  output logic [W-1:0]            quo_o,
  output logic                    done_o
);
  import ecapd_pkg::*;

  localparam int unsigned CntW = $clog2(W);

  logic            busy_q, phase_q, done_q;
  alu_op_e         op_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    a_q, b_q, acc_q, quo_q;

  logic [W-1:0] add_x, add_y, madd, diff, subres, redres, rsub;
  logic [W:0]   sum, rem2;
  logic         div_ge;

  // shared modular adder
  always_comb begin
    if (busy_q && phase_q) begin
      add_x = acc_q;
      add_y = a_q;
    end else if (busy_q) begin
      add_x = acc_q;
      add_y = acc_q;
    end else begin
      add_x = a_i;
      add_y = b_i;
    end
    sum  = {1'b0, add_x} + {1'b0, add_y};
    madd = (sum >= {1'b0, m_i}) ? W'(sum - {1'b0, m_i}) : sum[W-1:0];
  end

  // modular subtract and single reduction
  always_comb begin
    diff   = a_i - b_i;
    subres = (a_i >= b_i) ? diff : diff + m_i;
    redres = (a_i >= m_i) ? a_i - m_i : a_i;
  end

  // restoring divide step
  always_comb begin
    rem2   = {acc_q, b_q[W-1]};
    div_ge = rem2 >= {1'b0, a_q};
    rsub   = W'(rem2 - {1'b0, a_q});
  end

  // operation control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
      op_q    <= ALU_ADD;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q    <= req_i.op;
        phase_q <= 1'b0;
        cnt_q   <= '0;
        if (req_i.op == ALU_MUL || req_i.op == ALU_DIV) begin
          busy_q <= 1'b1;
        end else begin
          done_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (op_q == ALU_MUL) begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CntW'(W - 1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(W - 1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= '0;
      case (req_i.op)
        ALU_ADD: acc_q <= madd;
        ALU_SUB: acc_q <= subres;
        ALU_RED: acc_q <= redres;
        ALU_MUL: begin
          acc_q <= '0;
          a_q   <= a_i;
          b_q   <= b_i;
        end
        ALU_DIV: begin
          acc_q <= '0;
          a_q   <= b_i;
          b_q   <= a_i;
        end
        default: acc_q <= '0;
      endcase
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        if (!phase_q) begin
          acc_q <= madd;
        end else begin
          if (b_q[W-1]) acc_q <= madd;
          b_q <= {b_q[W-2:0], 1'b0};
        end
      end else begin
        acc_q <= div_ge ? rsub : rem2[W-1:0];
        quo_q <= {quo_q[W-2:0], div_ge};
        b_q   <= {b_q[W-2:0], 1'b0};
      end
    end
  end

  assign res_o  = acc_q;
  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### sv/ecapd_ctrl.sv
// ----------------------------------------------------------------------------
// ecapd_ctrl
// Sequencer and coordinate registers: reduces the operands, sorts out the
// special cases, runs the extended Euclid inverse and the slope formulas.
// ----------------------------------------------------------------------------
`default_nettype none

module ecapd_ctrl #(
  parameter int unsigned W = ecapd_pkg::FIELD_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  output logic                     done_o,
  input  wire logic                req_type_i,
  input  wire logic [W-1:0]        first_x_i,
  input  wire logic [W-1:0]        first_y_i,
  input  wire logic                first_z_i,
  input  wire logic [W-1:0]        second_x_i,
  input  wire logic [W-1:0]        second_y_i,
  input  wire logic                second_z_i,
  input  wire logic [W-1:0]        modulus_i,
  input  wire logic [W-1:0]        curve_a_i,
  output ecapd_pkg::alu_req_t      alu_req_o,
  output logic [W-1:0]             alu_a_o,
  output logic [W-1:0]             alu_b_o,
  input  wire logic [W-1:0]        alu_res_i,
  input  wire logic [W-1:0]        alu_quo_i,
  input  wire logic                alu_done_i,
  output logic                     ok_o,
  output logic [W-1:0]             result_x_o,
  output logic [W-1:0]             result_y_o,
  output logic                     result_z_o
);
  import ecapd_pkg::*;

  st_e          state_q, state_d;
  logic         issued_q, has_op, dbl_q, pz_q, qz_q;
  logic         ok_q, rz_q;
  alu_op_e      op;
  logic [W-1:0] px_q, py_q, qx_q, qy_q, ca_q, num_q, den_q;
  logic [W-1:0] r0_q, r1_q, t0_q, t1_q, qv_q, tmp_q, lam_q, rx_q, ry_q;
  logic [W:0]   ysum;
  logic         same_pt, inv_pair, small_mod;

  // special case tests
  always_comb begin
    ysum      = {1'b0, py_q} + {1'b0, qy_q};
    same_pt   = (px_q == qx_q) && (py_q == qy_q) && (pz_q == qz_q);
    inv_pair  = (px_q == qx_q) && ((ysum == '0) || (ysum == {1'b0, modulus_i}));
    small_mod = modulus_i < W'(2);
  end

  // next state and unit requests
  always_comb begin
    state_d = state_q;
    has_op  = 1'b0;
    op      = ALU_ADD;
    alu_a_o = '0;
    alu_b_o = '0;
    case (state_q)
      ST_IDLE: if (start_i) state_d = small_mod ? ST_DONE : ST_RPX;
      ST_RPX: begin
        has_op = 1'b1; op = ALU_DIV; alu_a_o = px_q; alu_b_o = modulus_i;
        if (alu_done_i) state_d = ST_RPY;
      end
      ST_RPY: begin
        has_op = 1'b1; op = ALU_DIV; alu_a_o = py_q; alu_b_o = modulus_i;
        if (alu_done_i) state_d = ST_RQX;
      end
      ST_RQX: begin
        has_op = 1'b1; op = ALU_DIV; alu_a_o = qx_q; alu_b_o = modulus_i;
        if (alu_done_i) state_d = ST_RQY;
      end
      ST_RQY: begin
        has_op = 1'b1; op = ALU_DIV; alu_a_o = qy_q; alu_b_o = modulus_i;
        if (alu_done_i) state_d = ST_RCA;
      end
      ST_RCA: begin
        has_op = 1'b1; op = ALU_DIV; alu_a_o = curve_a_i; alu_b_o = modulus_i;
        if (alu_done_i) state_d = ST_CHK;
      end
      ST_CHK: begin
        if (!dbl_q) begin
          if (same_pt || !pz_q || !qz_q || inv_pair) state_d = ST_DONE;
          else state_d = ST_NUM_SUB;
        end else begin
          if (!pz_q || py_q == '0) state_d = ST_DONE;
          else state_d = ST_SQX;
        end
      end
      ST_NUM_SUB: begin
        has_op = 1'b1; op = ALU_SUB; alu_a_o = qy_q; alu_b_o = py_q;
        if (alu_done_i) state_d = ST_DEN_SUB;
      end
      ST_DEN_SUB: begin
        has_op = 1'b1; op = ALU_SUB; alu_a_o = qx_q; alu_b_o = px_q;
        if (alu_done_i) state_d = ST_INIT;
      end
      ST_SQX: begin
        has_op = 1'b1; op = ALU_MUL; alu_a_o = px_q; alu_b_o = px_q;
        if (alu_done_i) state_d = ST_N1;
      end
      ST_N1: begin
        has_op = 1'b1; op = ALU_ADD; alu_a_o = tmp_q; alu_b_o = tmp_q;
        if (alu_done_i) state_d = ST_N2;
      end
      ST_N2: begin
        has_op = 1'b1; op = ALU_ADD; alu_a_o = num_q; alu_b_o = tmp_q;
        if (alu_done_i) state_d = ST_N3;
      end
      ST_N3: begin
        has_op = 1'b1; op = ALU_ADD; alu_a_o = num_q; alu_b_o = ca_q;
        if (alu_done_i) state_d = ST_D2;
      end
      ST_D2: begin
        has_op = 1'b1; op = ALU_ADD; alu_a_o = py_q; alu_b_o = py_q;
        if (alu_done_i) state_d = ST_INIT;
      end
      ST_INIT: state_d = ST_ITEST;
      ST_ITEST: begin
        if (r1_q != '0) state_d = ST_IDIV;
        else if (r0_q == W'(1)) state_d = ST_LAM;
        else state_d = ST_DONE;
      end
      ST_IDIV: begin
        has_op = 1'b1; op = ALU_DIV; alu_a_o = r0_q; alu_b_o = r1_q;
        if (alu_done_i) state_d = ST_IRED;
      end
      ST_IRED: begin
        has_op = 1'b1; op = ALU_RED; alu_a_o = qv_q;
        if (alu_done_i) state_d = ST_IMUL;
      end
      ST_IMUL: begin
        has_op = 1'b1; op = ALU_MUL; alu_a_o = qv_q; alu_b_o = t1_q;
        if (alu_done_i) state_d = ST_ISUB;
      end
      ST_ISUB: begin
        has_op = 1'b1; op = ALU_SUB; alu_a_o = t0_q; alu_b_o = qv_q;
        if (alu_done_i) state_d = ST_ITEST;
      end
      ST_LAM: begin
        has_op = 1'b1; op = ALU_MUL; alu_a_o = num_q; alu_b_o = t0_q;
        if (alu_done_i) state_d = ST_X1;
      end
      ST_X1: begin
        has_op = 1'b1; op = ALU_MUL; alu_a_o = lam_q; alu_b_o = lam_q;
        if (alu_done_i) state_d = ST_X2;
      end
      ST_X2: begin
        has_op = 1'b1; op = ALU_SUB; alu_a_o = tmp_q; alu_b_o = px_q;
        if (alu_done_i) state_d = ST_X3;
      end
      ST_X3: begin
        has_op = 1'b1; op = ALU_SUB; alu_a_o = tmp_q; alu_b_o = dbl_q ? px_q : qx_q;
        if (alu_done_i) state_d = ST_Y1;
      end
      ST_Y1: begin
        has_op = 1'b1; op = ALU_SUB; alu_a_o = px_q; alu_b_o = rx_q;
        if (alu_done_i) state_d = ST_Y2;
      end
      ST_Y2: begin
        has_op = 1'b1; op = ALU_MUL; alu_a_o = lam_q; alu_b_o = tmp_q;
        if (alu_done_i) state_d = ST_Y3;
      end
      ST_Y3: begin
        has_op = 1'b1; op = ALU_SUB; alu_a_o = tmp_q; alu_b_o = py_q;
        if (alu_done_i) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    alu_req_o.start = has_op && !issued_q;
    alu_req_o.op    = op;
  end

  // state register and request tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (alu_done_i) issued_q <= 1'b0;
      else if (alu_req_o.start) issued_q <= 1'b1;
    end
  end

  // coordinate and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (start_i) begin
        dbl_q <= req_type_i;
        px_q  <= first_x_i;
        py_q  <= first_y_i;
        pz_q  <= first_z_i;
        qx_q  <= second_x_i;
        qy_q  <= second_y_i;
        qz_q  <= second_z_i;
        ok_q  <= 1'b1;
        rx_q  <= '0;
        ry_q  <= W'(1);
        rz_q  <= 1'b0;
      end
      ST_RPX: if (alu_done_i) px_q <= pz_q ? alu_res_i : '0;
      ST_RPY: if (alu_done_i) py_q <= pz_q ? alu_res_i : W'(1);
      ST_RQX: if (alu_done_i) qx_q <= qz_q ? alu_res_i : '0;
      ST_RQY: if (alu_done_i) qy_q <= qz_q ? alu_res_i : W'(1);
      ST_RCA: if (alu_done_i) ca_q <= alu_res_i;
      ST_CHK: begin
        // default stays infinity; override for the copy and refusal cases
        if (!dbl_q) begin
          if (same_pt) begin
            ok_q <= 1'b0;
            ry_q <= '0;
          end else if (!pz_q) begin
            rx_q <= qx_q; ry_q <= qy_q; rz_q <= qz_q;
          end else if (!qz_q) begin
            rx_q <= px_q; ry_q <= py_q; rz_q <= pz_q;
          end
        end
      end
      ST_NUM_SUB: if (alu_done_i) num_q <= alu_res_i;
      ST_DEN_SUB: if (alu_done_i) den_q <= alu_res_i;
      ST_SQX:     if (alu_done_i) tmp_q <= alu_res_i;
      ST_N1:      if (alu_done_i) num_q <= alu_res_i;
      ST_N2:      if (alu_done_i) num_q <= alu_res_i;
      ST_N3:      if (alu_done_i) num_q <= alu_res_i;
      ST_D2:      if (alu_done_i) den_q <= alu_res_i;
      ST_INIT: begin
        r0_q <= modulus_i;
        r1_q <= den_q;
        t0_q <= '0;
        t1_q <= W'(1);
      end
      ST_IDIV: if (alu_done_i) begin
        qv_q  <= alu_quo_i;
        tmp_q <= alu_res_i;
      end
      ST_IRED: if (alu_done_i) qv_q <= alu_res_i;
      ST_IMUL: if (alu_done_i) qv_q <= alu_res_i;
      ST_ISUB: if (alu_done_i) begin
        r0_q <= r1_q;
        r1_q <= tmp_q;
        t0_q <= t1_q;
        t1_q <= alu_res_i;
      end
      ST_LAM: if (alu_done_i) lam_q <= alu_res_i;
      ST_X1:  if (alu_done_i) tmp_q <= alu_res_i;
      ST_X2:  if (alu_done_i) tmp_q <= alu_res_i;
      ST_X3:  if (alu_done_i) rx_q  <= alu_res_i;
      ST_Y1:  if (alu_done_i) tmp_q <= alu_res_i;
      ST_Y2:  if (alu_done_i) tmp_q <= alu_res_i;
      ST_Y3: if (alu_done_i) begin
        ry_q <= alu_res_i;
        rz_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_o     = state_q != ST_IDLE;
  assign done_o     = state_q == ST_DONE;
  assign ok_o       = ok_q;
  assign result_x_o = rx_q;
  assign result_y_o = ry_q;
  assign result_z_o = rz_q;

endmodule

`default_nettype wire

### sv/ec_affine_point_add_double_unit.sv
// ----------------------------------------------------------------------------
// ec_affine_point_add_double_unit
// Affine point add / double over GF(p) on one shared modular arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   Write modulus (index 0) and curve_a (index 1) through cfg_we_i while the
//   block is idle. An item is taken at a clock edge with start high and busy
//   low; busy then stays high until the result. The result shows on ok_o,
//   result_x_o, result_y_o and result_z_o with done_o high for one cycle and
//   is held until the next item is taken. The receiver cannot stall.
// Operation:
//   All arithmetic runs on one unit. Operand reduction costs 5 divides. The
//   inverse runs one Euclid iteration per divide, reduction, multiply and
//   subtract for up to roughly 1.5W iterations; the slope and result need
//   three multiplies for an add and four for a double.
//   A refused add, an infinity operand or an inverse pair ends after the
//   operand reduction and the special case check; a full add or double
//   takes its time from the Euclid loop on the shared unit.
//   A modulus below two answers in the cycle after the item is taken.
// Reset:
//   Returns to idle; modulus resets to 5 and curve_a to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_affine_point_add_double_unit #(
  parameter int unsigned FIELD_WIDTH = ecapd_pkg::FIELD_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ecapd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [FIELD_WIDTH-1:0]           cfg_data_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             req_type_i,
  input  wire logic [FIELD_WIDTH-1:0]           first_x_i,
  input  wire logic [FIELD_WIDTH-1:0]           first_y_i,
  input  wire logic                             first_z_i,
  input  wire logic [FIELD_WIDTH-1:0]           second_x_i,
  input  wire logic [FIELD_WIDTH-1:0]           second_y_i,
  input  wire logic                             second_z_i,
  output logic                                  done_o,
  output logic                                  ok_o,
  output logic [FIELD_WIDTH-1:0]                result_x_o,
  output logic [FIELD_WIDTH-1:0]                result_y_o,
  output logic                                  result_z_o
);
  import ecapd_pkg::*;

  logic [FIELD_WIDTH-1:0] modulus_q, curve_a_q;
  alu_req_t               alu_req;
  logic [FIELD_WIDTH-1:0] alu_a, alu_b, alu_res, alu_quo;
  logic                   alu_done;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= FIELD_WIDTH'(5);
      curve_a_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODULUS: modulus_q <= cfg_data_i;
        REG_CURVE_A: curve_a_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  ecapd_ctrl #(
    .W(FIELD_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .done_o     (done_o),
    .req_type_i (req_type_i),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .first_z_i  (first_z_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .second_z_i (second_z_i),
    .modulus_i  (modulus_q),
    .curve_a_i  (curve_a_q),
    .alu_req_o  (alu_req),
    .alu_a_o    (alu_a),
    .alu_b_o    (alu_b),
    .alu_res_i  (alu_res),
    .alu_quo_i  (alu_quo),
    .alu_done_i (alu_done),
    .ok_o       (ok_o),
    .result_x_o (result_x_o),
    .result_y_o (result_y_o),
    .result_z_o (result_z_o)
  );

  // shared arithmetic unit
  ecapd_alu #(
    .W(FIELD_WIDTH)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .m_i    (modulus_q),
    .res_o  (alu_res),
    .quo_o  (alu_quo),
    .done_o (alu_done)
  );

`ifndef SYNTHESIS
  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");

  // an accepted item keeps the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item accepted but block not busy");

  // a refused add returns all zero coordinates
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (result_x_o == '0 && result_y_o == '0 && !result_z_o))
    else $error("refused item with nonzero result");

  // the arithmetic unit gets no back-to-back start requests
  a_alu_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |=> !alu_req.start) else $error("back to back unit requests");
`endif

endmodule

`default_nettype wire
